>>> rtl/sync_length_frame_decoder_core_assert.svh
// assertion macros, empty when SYNTHESIS is defined
`ifndef SYNC_LENGTH_FRAME_DECODER_CORE_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SLDF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sldf assertion failed");

// antecedent implies consequent in the next cycle
`define SLDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sldf assertion failed");

`else

`define SLDF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SLDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/sldf_pkg.sv
package sldf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DATA_LEN = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET   = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET  = 8'hAA;
    localparam logic [LEN_W-1:0]  MAX_DATA_LEN_RESET = 16'd1024;

    typedef enum logic [5:0] {
        PH_HUNT1   = 6'b000001,
        PH_HUNT2   = 6'b000010,
        PH_LEN_LO  = 6'b000100,
        PH_LEN_HI  = 6'b001000,
        PH_CMD     = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [LEN_W-1:0]  max_data_len;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] payload_byte;
        logic              has_payload;
        logic [LEN_W-1:0]  payload_index;
        logic [LEN_W-1:0]  payload_total;
        logic              last;
    } result_t;

endpackage

>>> rtl/sldf_parser.sv
module sldf_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_accept,
    input  logic [sldf_pkg::BYTE_W-1:0] rx_byte,
    input  sldf_pkg::cfg_t              cfg,
    output sldf_pkg::result_t           result
);

    sldf_pkg::phase_t              phase_reg, phase_next;
    logic [sldf_pkg::LEN_W-1:0]    data_length_reg, data_length_next;
    logic [sldf_pkg::LEN_W-1:0]    data_position_reg, data_position_next;
    logic [sldf_pkg::BYTE_W-1:0]   held_command_reg, held_command_next;
    logic [sldf_pkg::LEN_W-1:0]    full_len;
    logic [sldf_pkg::LEN_W-1:0]    plen;
    logic [sldf_pkg::LEN_W:0]      pos_plus_one;
    logic                          last_byte;

    assign full_len     = {rx_byte, data_length_reg[sldf_pkg::BYTE_W-1:0]};
    assign plen         = data_length_reg - sldf_pkg::LEN_W'(1);
    assign pos_plus_one = {1'b0, data_position_reg} + (sldf_pkg::LEN_W+1)'(1);
    assign last_byte    = pos_plus_one >= {1'b0, plen};

    always_comb begin
        phase_next         = phase_reg;
        data_length_next   = data_length_reg;
        data_position_next = data_position_reg;
        held_command_next  = held_command_reg;
        result             = '0;
        unique case (phase_reg)
            sldf_pkg::PH_HUNT1: begin
                phase_next = (rx_byte == cfg.sync_first) ? sldf_pkg::PH_HUNT2
                                                         : sldf_pkg::PH_HUNT1;
            end
            sldf_pkg::PH_HUNT2: begin
                phase_next = (rx_byte == cfg.sync_second) ? sldf_pkg::PH_LEN_LO
                                                          : sldf_pkg::PH_HUNT1;
            end
            sldf_pkg::PH_LEN_LO: begin
                data_length_next = {{(sldf_pkg::LEN_W-sldf_pkg::BYTE_W){1'b0}}, rx_byte};
                phase_next       = sldf_pkg::PH_LEN_HI;
            end
            sldf_pkg::PH_LEN_HI: begin
                data_length_next = full_len;
                if (full_len == '0 || full_len > cfg.max_data_len) begin
                    phase_next = sldf_pkg::PH_HUNT1;
                end else begin
                    data_position_next = '0;
                    phase_next         = sldf_pkg::PH_CMD;
                end
            end
            sldf_pkg::PH_CMD: begin
                held_command_next  = rx_byte;
                data_position_next = '0;
                if (data_length_reg <= sldf_pkg::LEN_W'(1)) begin
                    result.valid   = 1'b1;
                    result.command = rx_byte;
                    result.last    = 1'b1;
                    phase_next     = sldf_pkg::PH_HUNT1;
                end else begin
                    phase_next = sldf_pkg::PH_PAYLOAD;
                end
            end
            sldf_pkg::PH_PAYLOAD: begin
                result.valid         = 1'b1;
                result.command       = held_command_reg;
                result.payload_byte  = rx_byte;
                result.has_payload   = 1'b1;
                result.payload_index = data_position_reg;
                result.payload_total = plen;
                result.last          = last_byte;
                data_position_next   = pos_plus_one[sldf_pkg::LEN_W-1:0];
                if (last_byte) begin
                    phase_next = sldf_pkg::PH_HUNT1;
                end
            end
            default: begin
                phase_next = sldf_pkg::PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= sldf_pkg::PH_HUNT1;
            data_length_reg   <= '0;
            data_position_reg <= '0;
            held_command_reg  <= '0;
        end else if (byte_accept) begin
            phase_reg         <= phase_next;
            data_length_reg   <= data_length_next;
            data_position_reg <= data_position_next;
            held_command_reg  <= held_command_next;
        end
    end

endmodule

>>> rtl/sync_length_frame_decoder_core.sv
// channel   direction  width  contents
// s_axis    in         8      tdata: rx_byte
// m_axis    out        48     tdata: command, payload_byte, payload_index, payload_total
//                             tuser: has_payload, tlast: last
// cfg_wr    in         16     register write, index 0..2
//
// one byte per cycle while s_tready is high; the result of each input transfer is registered in the output register
// the output register is refilled in the same cycle it is drained
// s_tready drops only while a result is held and m_tready is low
// synchronous active-low reset, no clearing pass
`include "sync_length_frame_decoder_core_assert.svh"

module sync_length_frame_decoder_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [sldf_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [sldf_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // command, payload_byte, payload_index, payload_total
    output logic [47:0]                      m_tdata,
    output logic                             m_tuser,  // has_payload
    output logic                             m_tlast
);

    sldf_pkg::cfg_t    cfg_reg;
    sldf_pkg::result_t result;
    sldf_pkg::result_t out_reg;
    logic              m_valid_reg;
    logic              in_transfer;

    assign s_tready    = !m_valid_reg || m_tready;
    assign in_transfer = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first   <= sldf_pkg::SYNC_FIRST_RESET;
            cfg_reg.sync_second  <= sldf_pkg::SYNC_SECOND_RESET;
            cfg_reg.max_data_len <= sldf_pkg::MAX_DATA_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                sldf_pkg::CFG_SYNC_FIRST:   cfg_reg.sync_first   <= cfg_wr_data[7:0];
                sldf_pkg::CFG_SYNC_SECOND:  cfg_reg.sync_second  <= cfg_wr_data[7:0];
                sldf_pkg::CFG_MAX_DATA_LEN: cfg_reg.max_data_len <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    sldf_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (in_transfer),
        .rx_byte     (s_tdata),
        .cfg         (cfg_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_transfer) begin
            m_valid_reg <= result.valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_transfer) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_reg.payload_total, out_reg.payload_index,
                       out_reg.payload_byte, out_reg.command};
    assign m_tuser  = out_reg.has_payload;
    assign m_tlast  = out_reg.last;

    `SLDF_ASSERT_SAME(a_cmd_only_last, aclk, aresetn, m_tvalid && !m_tuser, m_tlast && m_tdata[47:16] == 32'd0)
    `SLDF_ASSERT_SAME(a_index_in_range, aclk, aresetn, m_tvalid && m_tuser, m_tdata[31:16] < m_tdata[47:32])
    `SLDF_ASSERT_SAME(a_last_at_end, aclk, aresetn, m_tvalid && m_tuser && m_tlast, {1'b0, m_tdata[31:16]} + 17'd1 == {1'b0, m_tdata[47:32]})

endmodule
